// ===== rtl/dfps_pkg.sv =====
// shared constants and types for the dual fenwick prefix sum table
`timescale 1ns / 1ps

package dfps_pkg;

    localparam int SIZE      = 1024;
    localparam int ADDR_W    = $clog2(SIZE);
    localparam int IDX_W     = (ADDR_W + 2 > 12) ? ADDR_W + 2 : 12;
    localparam int POS_W     = 11;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 64;
    localparam int DELTA_W   = 32;

    localparam logic [1:0] OP_ADD_COUNT   = 2'd0;
    localparam logic [1:0] OP_ADD_SUM     = 2'd1;
    localparam logic [1:0] OP_QUERY_COUNT = 2'd2;
    localparam logic [1:0] OP_QUERY_SUM   = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/dual_fenwick_prefix_sum_table_unit.sv =====
// top level: dual fenwick tree walker over a count ram and a sum ram
//
//  channel  | handshake       | signals
//  ---------+-----------------+---------------------------------------------
//  command  | start / busy    | opcode, position, range_start, delta
//  result   | done (strobe)   | total, bad_index
//
// an update reads and writes back each tree entry on its path from position upward
// a range query walks two paths of up to 10 entries each
// a bad index skips the walk and returns a zero total with bad_index set
// one ram read port sets the walk rate; busy drops in the cycle done is high
// after reset both rams are cleared, every address to zero, with busy held high
// done is a one-cycle strobe; the receiver cannot stall it
`timescale 1ns / 1ps

module dual_fenwick_prefix_sum_table_unit
    import dfps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                opcode,
    input  logic [POS_W-1:0]          position,
    input  logic [POS_W-1:0]          range_start,
    input  logic signed [DELTA_W-1:0] delta,
    output logic                      done,
    output logic signed [SUM_W-1:0]   total,
    output logic                      bad_index
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [IDX_W-1:0]    second_reg, second_next;
    logic                has_second_reg, has_second_next;
    logic                neg_reg, neg_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                query_reg, query_next;
    logic                use_sum_reg, use_sum_next;
    logic [SUM_W-1:0]    delta_reg, delta_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic                done_reg, done_next;
    logic [SUM_W-1:0]    total_reg, total_next;
    logic                bad_reg, bad_next;

    logic                cnt_we, sum_we;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
    logic [SUM_W-1:0]    sum_wdata, sum_rdata;

    logic [IDX_W-1:0]    pos_ext, start_ext, k_low, k_m1;
    logic                k_live, in_query, in_sum, in_bad;
    logic [SUM_W-1:0]    rd_val;

    dfps_ram #(.WIDTH(CNT_W), .DEPTH(SIZE)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (waddr),
        .wdata (cnt_wdata),
        .raddr (raddr),
        .rdata (cnt_rdata)
    );

    dfps_ram #(.WIDTH(SUM_W), .DEPTH(SIZE)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (waddr),
        .wdata (sum_wdata),
        .raddr (raddr),
        .rdata (sum_rdata)
    );

    assign pos_ext   = {{(IDX_W-POS_W){1'b0}}, position};
    assign start_ext = {{(IDX_W-POS_W){1'b0}}, range_start};
    assign k_low     = k_reg & (~k_reg + {{(IDX_W-1){1'b0}}, 1'b1});
    assign k_m1      = k_reg - {{(IDX_W-1){1'b0}}, 1'b1};
    assign k_live    = (k_reg != '0) && (k_reg <= IDX_W'(SIZE));
    assign raddr     = k_m1[ADDR_W-1:0];
    assign rd_val    = use_sum_reg ? sum_rdata : {{(SUM_W-CNT_W){cnt_rdata[CNT_W-1]}}, cnt_rdata};

    assign in_query  = (opcode == OP_QUERY_COUNT) || (opcode == OP_QUERY_SUM);
    assign in_sum    = (opcode == OP_ADD_SUM) || (opcode == OP_QUERY_SUM);
    assign in_bad    = (position == '0) || (pos_ext > IDX_W'(SIZE)) ||
                       (in_query && ((range_start == '0) || (start_ext > IDX_W'(SIZE))));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        second_reg     <= second_next;
        has_second_reg <= has_second_next;
        neg_reg        <= neg_next;
        pend_addr_reg  <= pend_addr_next;
        query_reg      <= query_next;
        use_sum_reg    <= use_sum_next;
        delta_reg      <= delta_next;
        acc_reg        <= acc_next;
        total_reg      <= total_next;
        bad_reg        <= bad_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        k_next          = k_reg;
        second_next     = second_reg;
        has_second_next = has_second_reg;
        neg_next        = neg_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        query_next      = query_reg;
        use_sum_next    = use_sum_reg;
        delta_next      = delta_reg;
        acc_next        = acc_reg;
        done_next       = 1'b0;
        total_next      = total_reg;
        bad_next        = bad_reg;
        cnt_we          = 1'b0;
        sum_we          = 1'b0;
        waddr           = pend_addr_reg;
        cnt_wdata       = cnt_rdata + delta_reg[CNT_W-1:0];
        sum_wdata       = sum_rdata + delta_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                sum_we    = 1'b1;
                waddr     = clr_reg;
                cnt_wdata = '0;
                sum_wdata = '0;
                clr_next  = clr_reg + {{(ADDR_W-1){1'b0}}, 1'b1};
                if (clr_reg == ADDR_W'(SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    query_next      = in_query;
                    use_sum_next    = in_sum;
                    delta_next      = {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};
                    k_next          = pos_ext;
                    second_next     = start_ext - {{(IDX_W-1){1'b0}}, 1'b1};
                    has_second_next = in_query;
                    neg_next        = 1'b0;
                    acc_next        = '0;
                    if (in_bad)
                    begin
                        bad_next   = 1'b1;
                        total_next = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // read issued for k while the previous entry is folded in or written back
                if (k_live)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = raddr;
                    k_next         = query_reg ? (k_reg - k_low) : (k_reg + k_low);
                end
                if (pend_reg)
                begin
                    if (query_reg)
                    begin
                        acc_next = neg_reg ? (acc_reg - rd_val) : (acc_reg + rd_val);
                    end
                    else
                    begin
                        cnt_we = !use_sum_reg;
                        sum_we = use_sum_reg;
                    end
                end
                if (!k_live && !pend_reg)
                begin
                    if (has_second_reg)
                    begin
                        k_next          = second_reg;
                        has_second_next = 1'b0;
                        neg_next        = 1'b1;
                    end
                    else
                    begin
                        total_next = query_reg ? acc_reg : '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign total     = total_reg;
    assign bad_index = bad_reg;

endmodule

// ===== rtl/dfps_ram.sv =====
// simple dual-port ram, one write and one registered read per cycle
`timescale 1ns / 1ps

module dfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
